// ===== rtl/bspline_feasibility_penalty_macros.svh =====
// Assertion macros for the B-spline feasibility penalty block.
// Each macro expects clk_i and rst_ni in the scope where it is used.
`ifndef BSPLINE_FEASIBILITY_PENALTY_MACROS_SVH
`define BSPLINE_FEASIBILITY_PENALTY_MACROS_SVH

// Same-cycle implication.
`define BFP_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("bfp assertion failed");

// Next-cycle implication.
`define BFP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("bfp assertion failed");

`endif

// ===== rtl/bfp_pkg.sv =====
// ----------------------------------------------------------------------------
// bfp_pkg
// Shared types, constants and saturating helpers of the feasibility penalty.
// ----------------------------------------------------------------------------
package bfp_pkg;

  localparam int VAL_W    = 63;
  localparam int GRAD_W   = 48;
  localparam int COST_W   = 63;
  localparam int INV_W    = 23;
  localparam int LIM_W    = 31;
  localparam int CFG_W    = 31;
  localparam int CFG_IDX_W = 3;
  localparam int NUM_AXES = 3;

  typedef logic signed [VAL_W-1:0]  val_t;
  typedef logic signed [GRAD_W-1:0] grad_t;
  typedef logic [COST_W-1:0]        cost_t;

  localparam val_t  SATV = val_t'({1'b0, {(VAL_W-1){1'b1}}});
  localparam grad_t GMAX = grad_t'({1'b0, {(GRAD_W-1){1'b1}}});
  localparam cost_t CMAX = {COST_W{1'b1}};

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_INV_INTERVAL = 3'd0,
    REG_MAX_LIN_VEL  = 3'd1,
    REG_MAX_ANG_VEL  = 3'd2,
    REG_MAX_LIN_ACC  = 3'd3,
    REG_MAX_ANG_ACC  = 3'd4
  } reg_idx_e;

  typedef enum logic [4:0] {
    L_IDLE, L_I2, L_I3, L_I4, L_VD, L_VX, L_AD1, L_AD2, L_AD3, L_AX,
    L_PCL, L_PD, L_PSQ, L_PCUBE, L_NEAR_DC,
    L_PT1, L_PT2, L_PT3, L_PT4, L_PT5, L_PT6, L_PT7,
    L_VC, L_VG, L_AG, L_G0, L_G1, L_G1B, L_G2, L_DONE
  } lane_state_e;

  typedef enum logic [2:0] {
    PEN_NONE, PEN_HI_FAR, PEN_HI_NEAR, PEN_LO_FAR, PEN_LO_NEAR
  } pen_case_e;

  typedef enum logic [2:0] {
    T_IDLE, T_RUN, T_COST, T_EMIT, T_COMMIT
  } top_state_e;

  typedef struct packed {
    logic       start;
    logic       commit;
    logic       fin;
    logic [1:0] seen;
  } lane_cmd_t;

  typedef struct packed {
    logic [INV_W-1:0] inv;
    logic [LIM_W-1:0] lim_vel;
    logic [LIM_W-1:0] lim_acc;
  } lane_cfg_t;

  // a + b clamped to +-SATV
  function automatic val_t sadd(val_t a, val_t b);
    logic signed [VAL_W:0] s;
    logic signed [VAL_W:0] hi;
    s  = {a[VAL_W-1], a} + {b[VAL_W-1], b};
    hi = {1'b0, SATV};
    if (s > hi) begin
      return SATV;
    end else if (s < -hi) begin
      return -SATV;
    end
    return val_t'(s[VAL_W-1:0]);
  endfunction

  // 3a clamped; same as two chained saturating adds
  function automatic val_t times3(val_t a);
    logic signed [VAL_W+1:0] s;
    logic signed [VAL_W+1:0] hi;
    s  = {{2{a[VAL_W-1]}}, a} + {a[VAL_W-1], a, 1'b0};
    hi = {2'b00, SATV};
    if (s > hi) begin
      return SATV;
    end else if (s < -hi) begin
      return -SATV;
    end
    return val_t'(s[VAL_W-1:0]);
  endfunction

  // gradient slot update, clamped to the 48-bit range
  function automatic grad_t gadd(grad_t g, val_t v, logic sub);
    logic signed [VAL_W:0] ge;
    logic signed [VAL_W:0] ve;
    logic signed [VAL_W:0] s;
    logic signed [VAL_W:0] hi;
    ge = {{(VAL_W+1-GRAD_W){g[GRAD_W-1]}}, g};
    ve = {v[VAL_W-1], v};
    s  = sub ? (ge - ve) : (ge + ve);
    hi = {{(VAL_W+1-GRAD_W){1'b0}}, GMAX};
    if (s > hi) begin
      return GMAX;
    end else if (s < ~hi) begin
      return ~GMAX;
    end
    return grad_t'(s[GRAD_W-1:0]);
  endfunction

endpackage

// ===== rtl/bfp_mul.sv =====
// ----------------------------------------------------------------------------
// bfp_mul
// Saturating fixed-point multiplier, four 32x32 partial products in series.
// ----------------------------------------------------------------------------
module bfp_mul #(
  parameter int FRAC_BITS = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  bfp_pkg::val_t a_i,
  input  bfp_pkg::val_t b_i,
  output logic          done_o,
  output bfp_pkg::val_t res_o
);
  import bfp_pkg::*;

  logic [63:0]  ma_q, mb_q;
  logic         neg_q;
  logic [127:0] acc_q;
  logic [1:0]   cnt_q;
  logic         busy_q, fin_q, done_q;
  val_t         res_q;

  val_t         a_mag, b_mag, mag;
  logic [31:0]  a_half, b_half;
  logic [63:0]  pp, shifted;
  logic [127:0] pp_sh;
  logic         ovf;

  always_comb begin
    a_mag  = a_i[VAL_W-1] ? -a_i : a_i;
    b_mag  = b_i[VAL_W-1] ? -b_i : b_i;
    a_half = cnt_q[1] ? ma_q[63:32] : ma_q[31:0];
    b_half = cnt_q[0] ? mb_q[63:32] : mb_q[31:0];
    pp     = {32'd0, a_half} * {32'd0, b_half};
    case (cnt_q)
      2'd0:    pp_sh = {64'd0, pp};
      2'd1:    pp_sh = {32'd0, pp, 32'd0};
      2'd2:    pp_sh = {32'd0, pp, 32'd0};
      default: pp_sh = {pp, 64'd0};
    endcase
    shifted = acc_q[63:0] >> FRAC_BITS;
    // beyond 64 bits of product, or beyond the value bound after the shift
    ovf = (|acc_q[127:64]) || (|shifted[63:VAL_W-1]);
    mag = ovf ? SATV : val_t'(shifted[VAL_W-1:0]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      fin_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
      end else if (busy_q && cnt_q == 2'd3) begin
        busy_q <= 1'b0;
        fin_q  <= 1'b1;
      end else if (fin_q) begin
        fin_q  <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      ma_q  <= {1'b0, a_mag};
      mb_q  <= {1'b0, b_mag};
      neg_q <= a_i[VAL_W-1] ^ b_i[VAL_W-1];
      acc_q <= '0;
      cnt_q <= 2'd0;
    end else if (busy_q) begin
      acc_q <= acc_q + pp_sh;
      cnt_q <= cnt_q + 2'd1;
    end
    if (fin_q) begin
      res_q <= neg_q ? -mag : mag;
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

// ===== rtl/bfp_lane.sv =====
// ----------------------------------------------------------------------------
// bfp_lane
// One axis: window, velocity and acceleration penalty, pending gradients.
// ----------------------------------------------------------------------------
module bfp_lane #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  bfp_pkg::lane_cmd_t           cmd_i,
  input  bfp_pkg::lane_cfg_t           cfg_i,
  input  logic signed [DATA_WIDTH-1:0] point_i,
  output logic                         done_o,
  output bfp_pkg::val_t                cost_vel_o,
  output bfp_pkg::val_t                cost_acc_o,
  output bfp_pkg::grad_t [2:0]         grad_o
);
  import bfp_pkg::*;

  localparam val_t ONE_Q   = val_t'(64'd1 << FRAC_BITS);
  localparam val_t THREE_Q = val_t'(64'd3 << FRAC_BITS);

  lane_state_e state_q, state_d;
  logic        issued_q;
  logic        kind_q;  // 0: velocity term, 1: acceleration term
  pen_case_e   pcase_q, pcase_c;
  logic [1:0]  seen_q;
  val_t        p_q, w0_q, w1_q;
  grad_t [2:0] grad_q;
  val_t        i2_q, i3_q, i4_q, x_q, t_q, u_q, d_q, sq_q, c_q, dc_q, g_q, cv_q, ca_q;

  logic mul_state, mul_start, mul_done;
  val_t mul_a, mul_b, mul_res;
  val_t inv_v, lim_v, lim_p1;
  logic is_hi, is_near;

  bfp_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(mul_start),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .done_o (mul_done),
    .res_o  (mul_res)
  );

  always_comb begin
    inv_v  = val_t'({{(VAL_W-INV_W){1'b0}}, cfg_i.inv});
    lim_v  = kind_q ? val_t'({{(VAL_W-LIM_W){1'b0}}, cfg_i.lim_acc})
                    : val_t'({{(VAL_W-LIM_W){1'b0}}, cfg_i.lim_vel});
    lim_p1 = lim_v + ONE_Q;
    if (x_q > lim_p1) begin
      pcase_c = PEN_HI_FAR;
    end else if (x_q > lim_v) begin
      pcase_c = PEN_HI_NEAR;
    end else if (x_q < -lim_p1) begin
      pcase_c = PEN_LO_FAR;
    end else if (x_q < -lim_v) begin
      pcase_c = PEN_LO_NEAR;
    end else begin
      pcase_c = PEN_NONE;
    end
    is_hi   = (pcase_q == PEN_HI_FAR) || (pcase_q == PEN_HI_NEAR);
    is_near = (pcase_q == PEN_HI_NEAR) || (pcase_q == PEN_LO_NEAR);
  end

  // sequencer
  always_comb begin
    state_d   = state_q;
    mul_state = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    case (state_q)
      L_IDLE: begin
        if (cmd_i.start) begin
          state_d = (cmd_i.seen == 2'd0) ? L_DONE : L_I2;
        end
      end
      L_I2: begin
        mul_state = 1'b1; mul_a = inv_v; mul_b = inv_v;
        if (mul_done) state_d = L_I3;
      end
      L_I3: begin
        mul_state = 1'b1; mul_a = i2_q; mul_b = inv_v;
        if (mul_done) state_d = L_I4;
      end
      L_I4: begin
        mul_state = 1'b1; mul_a = i3_q; mul_b = inv_v;
        if (mul_done) state_d = L_VD;
      end
      L_VD: state_d = L_VX;
      L_VX: begin
        mul_state = 1'b1; mul_a = t_q; mul_b = inv_v;
        if (mul_done) state_d = L_PCL;
      end
      L_AD1: state_d = L_AD2;
      L_AD2: state_d = L_AD3;
      L_AD3: state_d = L_AX;
      L_AX: begin
        mul_state = 1'b1; mul_a = t_q; mul_b = i2_q;
        if (mul_done) state_d = L_PCL;
      end
      L_PCL: begin
        if (pcase_c == PEN_NONE) begin
          state_d = kind_q ? L_AG : L_VC;
        end else begin
          state_d = L_PD;
        end
      end
      L_PD: state_d = L_PSQ;
      L_PSQ: begin
        mul_state = 1'b1; mul_a = d_q; mul_b = d_q;
        if (mul_done) state_d = is_near ? L_PCUBE : L_PT1;
      end
      L_PCUBE: begin
        mul_state = 1'b1; mul_a = sq_q; mul_b = d_q;
        if (mul_done) state_d = L_NEAR_DC;
      end
      L_NEAR_DC: state_d = kind_q ? L_AG : L_VC;
      L_PT1: state_d = L_PT2;
      L_PT2: state_d = L_PT3;
      L_PT3: state_d = L_PT4;
      L_PT4: state_d = L_PT5;
      L_PT5: state_d = L_PT6;
      L_PT6: state_d = L_PT7;
      L_PT7: state_d = kind_q ? L_AG : L_VC;
      L_VC: begin
        mul_state = 1'b1; mul_a = c_q; mul_b = i3_q;
        if (mul_done) state_d = L_VG;
      end
      L_VG: begin
        mul_state = 1'b1; mul_a = dc_q; mul_b = i4_q;
        if (mul_done) state_d = L_G1;
      end
      L_AG: begin
        mul_state = 1'b1; mul_a = dc_q; mul_b = i2_q;
        if (mul_done) state_d = L_G0;
      end
      L_G0:  state_d = L_G1;
      L_G1:  state_d = kind_q ? L_G1B : L_G2;
      L_G1B: state_d = L_G2;
      L_G2:  state_d = (!kind_q && seen_q == 2'd2) ? L_AD1 : L_DONE;
      L_DONE: begin
        if (cmd_i.commit) state_d = L_IDLE;
      end
      default: state_d = L_IDLE;
    endcase
  end

  assign mul_start = mul_state && !issued_q;

  // control, window and pending gradients
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= L_IDLE;
      issued_q <= 1'b0;
      w0_q     <= '0;
      w1_q     <= '0;
      grad_q   <= '0;
    end else begin
      state_q <= state_d;
      if (mul_start) begin
        issued_q <= 1'b1;
      end else if (mul_done) begin
        issued_q <= 1'b0;
      end
      case (state_q)
        L_IDLE: begin
          if (cmd_i.start) begin
            grad_q[0] <= grad_q[1];
            grad_q[1] <= grad_q[2];
            grad_q[2] <= '0;
          end
        end
        L_G0:  grad_q[0] <= gadd(grad_q[0], g_q, 1'b0);
        L_G1:  grad_q[1] <= gadd(grad_q[1], g_q, 1'b1);
        L_G1B: grad_q[1] <= gadd(grad_q[1], g_q, 1'b1);
        L_G2:  grad_q[2] <= gadd(grad_q[2], g_q, 1'b0);
        L_DONE: begin
          if (cmd_i.commit) begin
            if (cmd_i.fin) begin
              w0_q   <= '0;
              w1_q   <= '0;
              grad_q <= '0;
            end else begin
              w0_q <= w1_q;
              w1_q <= p_q;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      L_IDLE: begin
        if (cmd_i.start) begin
          p_q    <= val_t'({{(VAL_W-DATA_WIDTH){point_i[DATA_WIDTH-1]}}, point_i});
          seen_q <= cmd_i.seen;
          cv_q   <= '0;
          ca_q   <= '0;
        end
      end
      L_I2: if (mul_done) i2_q <= mul_res;
      L_I3: if (mul_done) i3_q <= mul_res;
      L_I4: if (mul_done) i4_q <= mul_res;
      L_VD: t_q <= sadd(p_q, -w1_q);
      L_VX: begin
        kind_q <= 1'b0;
        if (mul_done) x_q <= mul_res;
      end
      L_AD1: t_q <= sadd(p_q, -w1_q);
      L_AD2: u_q <= sadd(w0_q, -w1_q);
      L_AD3: t_q <= sadd(t_q, u_q);
      L_AX: begin
        kind_q <= 1'b1;
        if (mul_done) x_q <= mul_res;
      end
      L_PCL: begin
        pcase_q <= pcase_c;
        c_q     <= '0;
        dc_q    <= '0;
      end
      L_PD: d_q <= is_hi ? sadd(x_q, -lim_v) : sadd(x_q, lim_v);
      L_PSQ: if (mul_done) sq_q <= mul_res;
      L_PCUBE: begin
        if (mul_done) c_q <= (pcase_q == PEN_LO_NEAR) ? -mul_res : mul_res;
      end
      L_NEAR_DC: dc_q <= (pcase_q == PEN_LO_NEAR) ? -times3(sq_q) : times3(sq_q);
      L_PT1: t_q  <= times3(sq_q);
      L_PT2: u_q  <= times3(d_q);
      L_PT3: c_q  <= is_hi ? sadd(t_q, -u_q) : sadd(t_q, u_q);
      L_PT4: c_q  <= sadd(c_q, ONE_Q);
      L_PT5: u_q  <= sadd(d_q, d_q);
      L_PT6: u_q  <= times3(u_q);
      L_PT7: dc_q <= is_hi ? sadd(u_q, -THREE_Q) : sadd(u_q, THREE_Q);
      L_VC: if (mul_done) cv_q <= mul_res;
      L_VG: if (mul_done) g_q <= mul_res;
      L_AG: begin
        ca_q <= c_q;
        if (mul_done) g_q <= mul_res;
      end
      default: ;
    endcase
  end

  assign done_o     = (state_q == L_DONE);
  assign cost_vel_o = cv_q;
  assign cost_acc_o = ca_q;
  assign grad_o     = grad_q;

endmodule

// ===== rtl/bspline_feasibility_penalty.sv =====
// ----------------------------------------------------------------------------
// bspline_feasibility_penalty
// Streaming velocity/acceleration feasibility penalty over B-spline points.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel (in_valid_i/in_ready_o) takes one control point per
//    transfer: x, y, yaw in signed Q.FRAC_BITS and final_point_i.
//  - Output channel (out_valid_o/out_ready_i) gives per-point gradients;
//    the last result of a trajectory carries run_end_o and the total cost.
//  - Config writes (cfg_we_i, cfg_index_i, cfg_data_i) are registered;
//    write only while the block is idle. Unknown indexes are ignored.
//  - One point is in flight at a time. Three axis lanes run in parallel,
//    each with its own sequenced datapath; every product goes through the
//    lane's shared multiplier (four 32x32 partial products in series, then
//    saturation). A full window needs up to 12 products, with register
//    steps between them; the first point of a trajectory needs none.
//  - After the lanes a cost merge sums the six lane cost terms, then 0 to 3
//    results are sent through an output register, one per transfer.
//  - A stalled receiver holds the result in the output register; the next
//    point is taken while the last result still waits.
//  - Reset restores the default limits and clears window, gradients, cost.
// ----------------------------------------------------------------------------
module bspline_feasibility_penalty #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [bfp_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [bfp_pkg::CFG_W-1:0]            cfg_data_i,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic signed [DATA_WIDTH-1:0]         point_x_i,
  input  logic signed [DATA_WIDTH-1:0]         point_y_i,
  input  logic signed [DATA_WIDTH-1:0]         point_yaw_i,
  input  logic                                 final_point_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output bfp_pkg::grad_t                       grad_x_o,
  output bfp_pkg::grad_t                       grad_y_o,
  output bfp_pkg::grad_t                       grad_yaw_o,
  output bfp_pkg::cost_t                       cost_total_o,
  output logic                                 run_end_o
);
  import bfp_pkg::*;

  // config registers
  logic [INV_W-1:0] inv_q;
  logic [LIM_W-1:0] lin_vel_q, ang_vel_q, lin_acc_q, ang_acc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inv_q     <= INV_W'(65536);
      lin_vel_q <= LIM_W'(19661);
      ang_vel_q <= LIM_W'(39322);
      lin_acc_q <= LIM_W'(39322);
      ang_acc_q <= LIM_W'(78643);
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_INV_INTERVAL: inv_q     <= cfg_data_i[INV_W-1:0];
        REG_MAX_LIN_VEL:  lin_vel_q <= cfg_data_i;
        REG_MAX_ANG_VEL:  ang_vel_q <= cfg_data_i;
        REG_MAX_LIN_ACC:  lin_acc_q <= cfg_data_i;
        REG_MAX_ANG_ACC:  ang_acc_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  top_state_e state_q, state_d;
  logic       fin_q;
  logic [1:0] seen_q, points_seen_q;
  cost_t      cost_sum_q;
  logic [2:0] cnt_q;
  logic [1:0] k_q;

  grad_t      gx_q, gy_q, gyaw_q;
  cost_t      cost_out_q;
  logic       run_end_q, out_valid_q;

  logic       accept, all_done, has_out, out_free, load;
  logic [1:0] first_k, last_k;
  lane_cmd_t  cmd;
  logic       lane_done [NUM_AXES];
  val_t       cost_arr [2*NUM_AXES];
  grad_t [2:0] lane_grad [NUM_AXES];
  logic signed [DATA_WIDTH-1:0] p_arr [NUM_AXES];

  val_t        c_sel;
  logic [COST_W:0] c_sum;

  assign p_arr[0] = point_x_i;
  assign p_arr[1] = point_y_i;
  assign p_arr[2] = point_yaw_i;

  assign cmd.start  = accept;
  assign cmd.commit = (state_q == T_COMMIT);
  assign cmd.fin    = fin_q;
  assign cmd.seen   = points_seen_q;

  for (genvar i = 0; i < NUM_AXES; i++) begin : g_lane
    lane_cfg_t cfg;
    assign cfg.inv     = inv_q;
    assign cfg.lim_vel = (i == NUM_AXES - 1) ? ang_vel_q : lin_vel_q;
    assign cfg.lim_acc = (i == NUM_AXES - 1) ? ang_acc_q : lin_acc_q;

    bfp_lane #(.DATA_WIDTH(DATA_WIDTH), .FRAC_BITS(FRAC_BITS)) u_lane (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .cmd_i     (cmd),
      .cfg_i     (cfg),
      .point_i   (p_arr[i]),
      .done_o    (lane_done[i]),
      .cost_vel_o(cost_arr[2*i]),
      .cost_acc_o(cost_arr[2*i+1]),
      .grad_o    (lane_grad[i])
    );
  end

  always_comb begin
    in_ready_o = (state_q == T_IDLE);
    accept     = in_valid_i && in_ready_o;
    all_done   = lane_done[0] && lane_done[1] && lane_done[2];
    // emitted slots: oldest pending first; a final point flushes all
    first_k    = (seen_q == 2'd2) ? 2'd0 : ((seen_q == 2'd1) ? 2'd1 : 2'd2);
    last_k     = fin_q ? 2'd2 : 2'd0;
    has_out    = fin_q || (seen_q == 2'd2);
    out_free   = !out_valid_q || out_ready_i;
    load       = (state_q == T_EMIT) && out_free;

    // merge: only positive penalty terms count, sum clamps at CMAX
    c_sel = (cnt_q < 3'(2*NUM_AXES)) ? cost_arr[cnt_q] : '0;
    if (c_sel[VAL_W-1]) c_sel = '0;
    c_sum = {1'b0, cost_sum_q} + {1'b0, cost_t'(c_sel)};

    state_d = state_q;
    case (state_q)
      T_IDLE:   if (accept) state_d = T_RUN;
      T_RUN:    if (all_done) state_d = T_COST;
      T_COST: begin
        if (cnt_q == 3'(2*NUM_AXES-1)) state_d = has_out ? T_EMIT : T_COMMIT;
      end
      T_EMIT:   if (out_free && k_q == last_k) state_d = T_COMMIT;
      T_COMMIT: state_d = T_IDLE;
      default:  state_d = T_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= T_IDLE;
      fin_q         <= 1'b0;
      seen_q        <= 2'd0;
      points_seen_q <= 2'd0;
      cost_sum_q    <= '0;
      cnt_q         <= 3'd0;
      k_q           <= 2'd0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        T_IDLE: begin
          if (accept) begin
            fin_q  <= final_point_i;
            seen_q <= points_seen_q;
            cnt_q  <= 3'd0;
          end
        end
        T_COST: begin
          cost_sum_q <= c_sum[COST_W] ? CMAX : c_sum[COST_W-1:0];
          cnt_q      <= cnt_q + 3'd1;
          k_q        <= first_k;
        end
        T_EMIT: if (out_free) k_q <= k_q + 2'd1;
        T_COMMIT: begin
          if (fin_q) begin
            points_seen_q <= 2'd0;
            cost_sum_q    <= '0;
          end else begin
            points_seen_q <= (seen_q == 2'd2) ? 2'd2 : seen_q + 2'd1;
          end
        end
        default: ;
      endcase
    end
  end

  // output register payload
  always_ff @(posedge clk_i) begin
    if (load) begin
      gx_q       <= lane_grad[0][k_q];
      gy_q       <= lane_grad[1][k_q];
      gyaw_q     <= lane_grad[2][k_q];
      cost_out_q <= (fin_q && k_q == 2'd2) ? cost_sum_q : '0;
      run_end_q  <= fin_q && (k_q == 2'd2);
    end
  end

  assign out_valid_o  = out_valid_q;
  assign grad_x_o     = gx_q;
  assign grad_y_o     = gy_q;
  assign grad_yaw_o   = gyaw_q;
  assign cost_total_o = cost_out_q;
  assign run_end_o    = run_end_q;

endmodule

// ===== rtl/bfp_checker.sv =====
// ----------------------------------------------------------------------------
// bfp_checker
// Port-level checks of the feasibility penalty block, bound to the top.
// ----------------------------------------------------------------------------
`include "bspline_feasibility_penalty_macros.svh"

module bfp_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_valid_i,
  input logic           in_ready_o,
  input logic           out_valid_o,
  input logic           out_ready_i,
  input bfp_pkg::grad_t grad_x_o,
  input bfp_pkg::cost_t cost_total_o,
  input logic           run_end_o
);
  import bfp_pkg::*;

  `BFP_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o)
  `BFP_ASSERT_NEXT(a_out_stable, out_valid_o && !out_ready_i, $stable(grad_x_o) && $stable(cost_total_o))
  `BFP_ASSERT_IMPL(a_cost_on_end, out_valid_o && !run_end_o, cost_total_o == '0)
  `BFP_ASSERT_NEXT(a_one_point, in_valid_i && in_ready_o, !in_ready_o)

endmodule

bind bspline_feasibility_penalty bfp_checker u_bfp_checker (.*);
